// ----- rtl/tgma_pkg.sv -----
// ----------------------------------------------------------------------------
// tgma_pkg
// Shared types, step codes and the microcode table of the threshold-gated
// moving average sequencer.
// ----------------------------------------------------------------------------
package tgma_pkg;

    // reading, threshold and average width
    localparam int DATA_W = 24;
    typedef logic signed [DATA_W-1:0] t_data;

    // program steps
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;
    localparam t_step STEP_IDLE    = 3'd0;
    localparam t_step STEP_GATE    = 3'd1;
    localparam t_step STEP_ISSUE   = 3'd2;
    localparam t_step STEP_WALK    = 3'd3;
    localparam t_step STEP_DIVPREP = 3'd4;
    localparam t_step STEP_DIVSTEP = 3'd5;
    localparam t_step STEP_DIVEND  = 3'd6;
    localparam t_step STEP_FINISH  = 3'd7;

    // datapath operations
    typedef logic [3:0] t_op;
    localparam t_op OP_NONE    = 4'd0;
    localparam t_op OP_ACCEPT  = 4'd1;
    localparam t_op OP_GATE    = 4'd2;
    localparam t_op OP_ISSUE   = 4'd3;
    localparam t_op OP_WALK    = 4'd4;
    localparam t_op OP_DIVPREP = 4'd5;
    localparam t_op OP_DIVSTEP = 4'd6;
    localparam t_op OP_DIVEND  = 4'd7;
    localparam t_op OP_EMIT    = 4'd8;

    // jump conditions
    typedef logic [2:0] t_cond;
    localparam t_cond COND_NEVER      = 3'd0;
    localparam t_cond COND_NO_INPUT   = 3'd1;
    localparam t_cond COND_BELOW      = 3'd2;
    localparam t_cond COND_MORE_SLOTS = 3'd3;
    localparam t_cond COND_DIV_MORE   = 3'd4;
    localparam t_cond COND_OUT_BUSY   = 3'd5;

    // one control word
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_ctrl;

    // status from the datapath back to the sequencer
    typedef struct packed {
        logic no_input;
        logic below;
        logic more_slots;
        logic div_more;
        logic out_busy;
    } t_flags;

    // microcode table; a step whose condition fails goes on to the next step,
    // and the last step wraps round to idle
    function automatic t_ctrl rom(input t_step step);
        t_ctrl w;
        unique case (step)
            STEP_IDLE:    w = '{OP_ACCEPT,  COND_NO_INPUT,   STEP_IDLE};
            STEP_GATE:    w = '{OP_GATE,    COND_BELOW,      STEP_FINISH};
            STEP_ISSUE:   w = '{OP_ISSUE,   COND_NEVER,      STEP_IDLE};
            STEP_WALK:    w = '{OP_WALK,    COND_MORE_SLOTS, STEP_WALK};
            STEP_DIVPREP: w = '{OP_DIVPREP, COND_NEVER,      STEP_IDLE};
            STEP_DIVSTEP: w = '{OP_DIVSTEP, COND_DIV_MORE,   STEP_DIVSTEP};
            STEP_DIVEND:  w = '{OP_DIVEND,  COND_NEVER,      STEP_IDLE};
            STEP_FINISH:  w = '{OP_EMIT,    COND_OUT_BUSY,   STEP_FINISH};
            default:      w = '{OP_NONE,    COND_NEVER,      STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/tgma_ram.sv -----
// ----------------------------------------------------------------------------
// tgma_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tgma_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tgma_seq.sv -----
// ----------------------------------------------------------------------------
// tgma_seq
// Microcode sequencer: step counter, control store lookup and conditional
// jumps on datapath status.
// ----------------------------------------------------------------------------
module tgma_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tgma_pkg::t_flags i_flags,
    output tgma_pkg::t_ctrl  o_ctrl
);

    tgma_pkg::t_step r_step;
    tgma_pkg::t_step n_step;
    tgma_pkg::t_ctrl w_ctrl;
    logic            w_jump;

    // control word of the current step
    assign w_ctrl = tgma_pkg::rom(r_step);

    // jump condition select
    always_comb begin
        unique case (w_ctrl.cond)
            tgma_pkg::COND_NEVER:      w_jump = 1'b0;
            tgma_pkg::COND_NO_INPUT:   w_jump = i_flags.no_input;
            tgma_pkg::COND_BELOW:      w_jump = i_flags.below;
            tgma_pkg::COND_MORE_SLOTS: w_jump = i_flags.more_slots;
            tgma_pkg::COND_DIV_MORE:   w_jump = i_flags.div_more;
            tgma_pkg::COND_OUT_BUSY:   w_jump = i_flags.out_busy;
            default:                   w_jump = 1'b0;
        endcase
    end

    // next step: jump target or fall through (wraps to idle after the last)
    assign n_step = w_jump ? w_ctrl.target : r_step + tgma_pkg::t_step'(1);

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= tgma_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = w_ctrl;

endmodule

// ----- rtl/tgma_dp.sv -----
// ----------------------------------------------------------------------------
// tgma_dp
// Datapath: threshold register, ring window with valid bits, accumulator,
// bit-serial divider, held average and output register.
// ----------------------------------------------------------------------------
module tgma_dp #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tgma_pkg::t_ctrl  i_ctrl,
    output tgma_pkg::t_flags o_flags,
    input  logic             i_valid,
    input  tgma_pkg::t_data  i_sample,
    input  logic             i_ready,
    output logic             o_valid,
    output tgma_pkg::t_data  o_average,
    output logic             o_accepted,
    input  logic             i_cfg_we,
    input  tgma_pkg::t_data  i_cfg_data
);

    localparam int DW     = tgma_pkg::DATA_W;
    localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = DW + $clog2(WINDOW_DEPTH);
    localparam int DIVC_W = $clog2(SUM_W);

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [DIVC_W-1:0] LAST_DIVC = DIVC_W'(SUM_W - 1);

    // threshold and window state
    tgma_pkg::t_data          r_thresh;
    tgma_pkg::t_data          r_sample;
    logic [WINDOW_DEPTH-1:0]  r_slot_valid;
    logic [IDX_W-1:0]         r_slot;
    logic [IDX_W-1:0]         r_rd_idx;

    // accumulate and divide
    logic signed [SUM_W-1:0]  r_acc;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_neg;
    logic [SUM_W-1:0]         r_quo;
    logic [CNT_W-1:0]         r_rem;
    logic [DIVC_W-1:0]        r_div_cnt;

    // held result and output register
    tgma_pkg::t_data          r_avg;
    logic                     r_flag;
    logic                     r_out_valid;
    tgma_pkg::t_data          r_out_avg;
    logic                     r_out_acc;

    logic                     w_below;
    logic                     w_out_busy;
    logic                     w_ram_we;
    logic [IDX_W-1:0]         w_raddr;
    logic [IDX_W-1:0]         w_rd_next;
    logic [DW-1:0]            w_rdata;
    tgma_pkg::t_data          w_rd_sdata;
    logic                     w_qualifies;
    logic [SUM_W-1:0]         w_acc_mag;
    logic [CNT_W:0]           w_trial;
    logic                     w_fits;
    tgma_pkg::t_data          w_quo_low;

    // gate compare and output back-pressure
    assign w_below    = r_sample < r_thresh;
    assign w_out_busy = r_out_valid && !i_ready;

    // window read pointer: slot zero on issue, then the following slot
    assign w_rd_next = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + IDX_W'(1);
    assign w_raddr   = (i_ctrl.op == tgma_pkg::OP_ISSUE) ? '0 : w_rd_next;
    assign w_ram_we  = (i_ctrl.op == tgma_pkg::OP_GATE) && !w_below;

    tgma_ram #(
        .WIDTH (DW),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // entry read back counts if written and still at or above threshold
    assign w_rd_sdata  = $signed(w_rdata);
    assign w_qualifies = r_slot_valid[r_rd_idx] && (w_rd_sdata >= r_thresh);

    // magnitude of the sum and one restoring divide step
    assign w_acc_mag = r_acc[SUM_W-1] ? (~r_acc + SUM_W'(1)) : r_acc;
    assign w_trial   = {r_rem, r_quo[SUM_W-1]};
    assign w_fits    = w_trial >= {1'b0, r_cnt};
    assign w_quo_low = r_quo[DW-1:0];

    // status to the sequencer
    assign o_flags.no_input   = !i_valid;
    assign o_flags.below      = w_below;
    assign o_flags.more_slots = r_rd_idx != LAST_IDX;
    assign o_flags.div_more   = r_div_cnt != LAST_DIVC;
    assign o_flags.out_busy   = w_out_busy;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh     <= '0;
            r_slot_valid <= '0;
            r_slot       <= '0;
            r_avg        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_data;
            end
            if (w_ram_we) begin
                r_slot_valid[r_slot] <= 1'b1;
                r_slot <= (r_slot == LAST_IDX) ? '0 : r_slot + IDX_W'(1);
            end
            if (i_ctrl.op == tgma_pkg::OP_DIVEND && r_cnt != '0) begin
                r_avg <= r_neg ? -w_quo_low : w_quo_low;
            end
            if (i_ctrl.op == tgma_pkg::OP_EMIT && !w_out_busy) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers, driven by the current control word
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            tgma_pkg::OP_ACCEPT: begin
                if (i_valid) begin
                    r_sample <= i_sample;
                end
            end
            tgma_pkg::OP_GATE: begin
                r_flag <= !w_below;
                r_acc  <= '0;
                r_cnt  <= '0;
            end
            tgma_pkg::OP_ISSUE: begin
                r_rd_idx <= '0;
            end
            tgma_pkg::OP_WALK: begin
                if (w_qualifies) begin
                    r_acc <= r_acc + SUM_W'(w_rd_sdata);
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                r_rd_idx <= w_rd_next;
            end
            tgma_pkg::OP_DIVPREP: begin
                r_neg     <= r_acc[SUM_W-1];
                r_quo     <= w_acc_mag;
                r_rem     <= '0;
                r_div_cnt <= '0;
            end
            tgma_pkg::OP_DIVSTEP: begin
                r_quo     <= {r_quo[SUM_W-2:0], w_fits};
                r_rem     <= w_fits ? CNT_W'(w_trial - {1'b0, r_cnt})
                                    : w_trial[CNT_W-1:0];
                r_div_cnt <= r_div_cnt + DIVC_W'(1);
            end
            tgma_pkg::OP_EMIT: begin
                if (!w_out_busy) begin
                    r_out_avg <= r_avg;
                    r_out_acc <= r_flag;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid    = r_out_valid;
    assign o_average  = r_out_avg;
    assign o_accepted = r_out_acc;

endmodule

// ----- rtl/threshold_gated_moving_average.sv -----
// ----------------------------------------------------------------------------
// threshold_gated_moving_average
// Threshold-gated moving average of signed load-cell readings, run by a
// microcoded sequencer over a ring window RAM and a bit-serial divider.
// ----------------------------------------------------------------------------
// Usage
//   Input channel i_valid/o_ready carries one 24-bit signed reading per
//   transfer; output channel o_valid/i_ready returns the held average and an
//   accepted flag, one result per reading, in order.
//   i_cfg_we/i_cfg_data write the threshold; write it only while idle.
//   A reading below the threshold leaves window and average untouched; the
//   sequencer goes from the gate step straight to the finish step, and the
//   next reading is taken only once the result is in the output register.
//   An accepted reading walks every window slot (one RAM read a cycle) and
//   then runs a restoring divide, one quotient bit a cycle over
//   24 + log2(WINDOW_DEPTH) bits; the next reading is taken only once the
//   result is in the output register.
//   The result sits in an output register, so the next reading is taken
//   while it waits; if the receiver stalls, the sequencer holds at its last
//   step until the register frees.
//   Reset (synchronous, active low) empties the window, zeroes the write
//   slot, held average and threshold; no clearing pass is needed.
// ----------------------------------------------------------------------------
module threshold_gated_moving_average #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tgma_pkg::t_data i_sample,
    output logic            o_valid,
    input  logic            i_ready,
    output tgma_pkg::t_data o_average,
    output logic            o_accepted,
    input  logic            i_cfg_we,
    input  tgma_pkg::t_data i_cfg_data
);

    tgma_pkg::t_ctrl  w_ctrl;
    tgma_pkg::t_flags w_flags;

    // sequencer
    tgma_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    // datapath
    tgma_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .o_flags    (w_flags),
        .i_valid    (i_valid),
        .i_sample   (i_sample),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_average  (o_average),
        .o_accepted (o_accepted),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // a reading transfers only on the idle step
    assign o_ready = w_ctrl.op == tgma_pkg::OP_ACCEPT;

endmodule

// ----- verif/tb_threshold_gated_moving_average.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_threshold_gated_moving_average
// Self-checking bench for the threshold-gated moving average. Readings go in
// through the valid/ready input channel and each transfer is scored against a
// local copy of the ring window, slot flags and held average; every result is
// checked in order. Directed tests cover reset state, both threshold extremes
// and threshold moves over stored entries, then random phases run with fresh
// thresholds, random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module tb_threshold_gated_moving_average;

    typedef tgma_pkg::t_data t_data;

    localparam int    WINDOW_DEPTH = 16;
    localparam int    IDLE_LIMIT   = 3000;
    localparam t_data READING_MIN  = 24'sh800000;
    localparam t_data READING_MAX  = 24'sh7FFFFF;

    typedef struct {
        t_data average;
        logic  accepted;
    } t_avg_result;

    logic  i_clk;
    logic  i_rst_n    = 1'b0;
    logic  i_valid    = 1'b0;
    logic  o_ready;
    t_data i_sample   = '0;
    logic  o_valid;
    logic  i_ready    = 1'b0;
    t_data o_average;
    logic  o_accepted;
    logic  i_cfg_we   = 1'b0;
    t_data i_cfg_data = '0;

    // local copy of the block state
    t_data       window_copy [WINDOW_DEPTH];
    bit          slot_used [WINDOW_DEPTH];
    int          next_slot;
    t_data       held_avg;
    t_data       threshold_copy;
    t_avg_result pending_averages [$];
    t_avg_result head;

    bit          gaps_on;
    bit          stalls_on;
    int unsigned stall_left;
    int          mismatch_count;
    int          idle_cycles;

    threshold_gated_moving_average #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sample   (i_sample),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_average  (o_average),
        .o_accepted (o_accepted),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // gap length: mostly short, a few long
    function automatic int unsigned draw_gap(input bit allow_zero);
        int unsigned r;
        r = $urandom_range(99);
        if (allow_zero && r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // work out the result of one transferred reading
    task automatic predict_average(input t_data reading);
        longint      total;
        int          members;
        t_avg_result res;
        total   = 0;
        members = 0;
        res.accepted = 1'b0;
        if (reading >= threshold_copy) begin
            window_copy[next_slot] = reading;
            slot_used[next_slot]   = 1'b1;
            next_slot = (next_slot + 1 >= WINDOW_DEPTH) ? 0 : next_slot + 1;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                if (slot_used[i] && window_copy[i] >= threshold_copy) begin
                    total   += longint'(window_copy[i]);
                    members += 1;
                end
            end
            // division truncates toward zero
            if (members > 0) held_avg = t_data'(total / longint'(members));
            res.accepted = 1'b1;
        end
        res.average = held_avg;
        pending_averages.push_back(res);
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // one reading per call; valid stays up when the next call follows at once
    task automatic send_reading(input t_data reading);
        int unsigned gap;
        gap = gaps_on ? draw_gap(1'b1) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= reading;
        do @(posedge i_clk); while (!o_ready);
        predict_average(reading);
    endtask

    task automatic wait_drained();
        while (pending_averages.size() != 0) @(posedge i_clk);
    endtask

    // threshold write while idle
    task automatic write_threshold(input t_data value);
        i_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        threshold_copy = value;
        i_cfg_we <= 1'b0;
    endtask

    // random reading biased toward the accepted range and the edges
    function automatic t_data draw_reading();
        int unsigned r;
        int          span;
        r    = $urandom_range(99);
        span = int'(READING_MAX) - int'(threshold_copy);
        if (r < 15) return t_data'(int'(threshold_copy) + int'($urandom_range(3, 0)));
        if (r < 65) return t_data'(int'(threshold_copy) + int'($urandom_range(span, 0)));
        if (r < 72) return READING_MAX;
        if (r < 77) return READING_MIN;
        if (r < 82) return t_data'(int'(threshold_copy) - 1);
        return t_data'($urandom_range(24'hFFFFFF, 0));
    endfunction

    // receiver stalls
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= (stall_left == 1);
        end else if (stalls_on && $urandom_range(99) < 20) begin
            stall_left <= draw_gap(1'b0);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_averages.size() == 0) begin
                report_mismatch($sformatf("unexpected result average %0d accepted %0b",
                                          o_average, o_accepted));
            end else begin
                head = pending_averages.pop_front();
                if (o_average !== head.average)
                    report_mismatch($sformatf("average %0d, expected %0d",
                                              o_average, head.average));
                if (o_accepted !== head.accepted)
                    report_mismatch($sformatf("accepted %0b, expected %0b",
                                              o_accepted, head.accepted));
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // empty window, zero threshold after reset
    task automatic test_reset_state();
        send_reading(-24'sd1);
        send_reading(24'sd0);
        send_reading(READING_MAX);
        send_reading(READING_MIN);
    endtask

    // lowest threshold, extreme readings and signed truncation
    task automatic test_lowest_threshold();
        write_threshold(READING_MIN);
        send_reading(READING_MIN);
        send_reading(READING_MIN);
        send_reading(READING_MAX);
        send_reading(-24'sd1);
        send_reading(24'sd1);
        send_reading(-24'sd3);
    endtask

    // threshold moved over stored entries, readings at and just under it
    task automatic test_threshold_moves();
        write_threshold(24'sd100);
        send_reading(24'sd99);
        send_reading(24'sd100);
        write_threshold(-24'sd5);
        send_reading(-24'sd5);
        send_reading(-24'sd6);
    endtask

    // top threshold: only the largest reading passes
    task automatic test_top_threshold();
        write_threshold(READING_MAX);
        send_reading(READING_MAX - 24'sd1);
        send_reading(READING_MAX);
    endtask

    // random phases, each with its own threshold and idling mix
    task automatic test_random_phases();
        t_data thr;
        for (int ph = 0; ph < 13; ph++) begin
            case (ph)
                0: thr = READING_MIN;
                1: thr = READING_MAX;
                2: thr = '0;
                default: begin
                    if ($urandom_range(1)) thr = t_data'($urandom_range(24'hFFFFFF, 0));
                    else thr = t_data'(int'($urandom_range(2000, 0)) - 1000);
                end
            endcase
            write_threshold(thr);
            gaps_on   = (ph % 3 != 0);
            stalls_on = (ph % 4 != 1);
            repeat (50) send_reading(draw_reading());
        end
    endtask

    // main sequence
    initial begin
        foreach (slot_used[i]) begin
            slot_used[i]   = 1'b0;
            window_copy[i] = '0;
        end
        next_slot      = 0;
        held_avg       = '0;
        threshold_copy = '0;
        gaps_on        = 1'b1;
        stalls_on      = 1'b1;
        stall_left     = 0;
        mismatch_count = 0;
        idle_cycles    = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_lowest_threshold();
        test_threshold_moves();
        test_top_threshold();
        test_random_phases();

        i_valid <= 1'b0;
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
